>>> design/tamahi_pkg.sv
// Shared types, constants and opcodes of the three-axis moving-average block.
`default_nettype none
package tamahi_pkg;

	localparam int WINDOW_LEN     = 10;
	localparam int GAIN_FRAC_BITS = 14;

	localparam int AXIS_W   = 16;
	localparam int GAIN_W   = 16;
	localparam int CORR_W   = AXIS_W + 1;
	localparam int PROD_W   = AXIS_W + GAIN_W + 1;
	localparam int SUM_W    = AXIS_W + $clog2(WINDOW_LEN) + 1;
	localparam int ABS_W    = $clog2(WINDOW_LEN * (2 ** (AXIS_W - 1)) + 1);
	localparam int MEAN_SHIFT = ABS_W + $clog2(WINDOW_LEN);
	localparam int MEAN_MULT  = (2 ** MEAN_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam int MULT_W     = $clog2(MEAN_MULT + 1);
	localparam int SAT_MAX    = 2 ** (AXIS_W - 1) - 1;
	localparam int SAT_MIN    = -(2 ** (AXIS_W - 1));
	localparam int GAIN_RESET = 2 ** GAIN_FRAC_BITS;

	localparam int NUM_REGS = 3;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_INV_GAIN_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INV_GAIN_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_GAIN_Z = 2'd2;

	typedef enum logic [2:0] {
		OP_SAMPLE    = 3'd0,
		OP_CAL_START = 3'd1,
		OP_CAL_END   = 3'd2,
		OP_LOAD_MIN  = 3'd3,
		OP_LOAD_MAX  = 3'd4
	} opcode_t;

	typedef struct packed {
		logic    ld_s1;
		logic    ld_s2;
		logic    ld_s3;
		logic    ld_s4;
		logic    ld_s5;
		logic    ld_s6;
		logic    push_s2;
		opcode_t op_s4;
		logic    track;
	} pipe_ctl_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] avg;
		logic signed [AXIS_W-1:0] lo;
		logic signed [AXIS_W-1:0] hi;
	} lane_res_t;

endpackage
`default_nettype wire

>>> design/tamahi_lane.sv
// One axis lane: gain scaling, window with running sum, divide by length, extremes.
`default_nettype none
module tamahi_lane (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  tamahi_pkg::pipe_ctl_t                   ctl,
	input  wire        [tamahi_pkg::GAIN_W-1:0]     gain,
	input  wire signed [tamahi_pkg::AXIS_W-1:0]     axis,
	output tamahi_pkg::lane_res_t                   res
);

	localparam int AW = tamahi_pkg::AXIS_W;
	localparam int PW = tamahi_pkg::PROD_W;
	localparam int SW = tamahi_pkg::SUM_W;
	localparam int NW = tamahi_pkg::WINDOW_LEN;
	localparam int FB = tamahi_pkg::GAIN_FRAC_BITS;
	localparam int BW = tamahi_pkg::ABS_W;
	localparam int MW = tamahi_pkg::MULT_W;

	logic signed [tamahi_pkg::GAIN_W:0] gain_s;
	logic signed [PW-1:0]               prod_s1;
	logic signed [AW-1:0]               val_s1, val_s2, val_s3, val_s4;
	logic signed [PW-1:0]               bias;
	logic signed [PW-1:0]               quo;
	logic signed [AW-1:0]               scaled;
	logic signed [AW-1:0]               scaled_s2;
	logic signed [AW-1:0]               win_q [NW];
	logic signed [SW-1:0]               sum_q;
	logic signed [SW-1:0]               sum_next;
	logic        [SW-1:0]               sum_abs;
	logic        [BW+MW-1:0]            prod_s4;
	logic                               neg_s4;
	logic        [AW:0]                 qmag;
	logic signed [AW-1:0]               mean;
	logic signed [AW-1:0]               avg_q, lo_q, hi_q;

	assign gain_s = $signed({1'b0, gain});

	// truncate toward zero, then saturate
	assign bias   = prod_s1[PW-1] ? PW'((2 ** FB) - 1) : '0;
	assign quo    = (prod_s1 + bias) >>> FB;
	always_comb begin
		if (quo > PW'(tamahi_pkg::SAT_MAX)) begin
			scaled = AW'(tamahi_pkg::SAT_MAX);
		end else if (quo < PW'(tamahi_pkg::SAT_MIN)) begin
			scaled = AW'(tamahi_pkg::SAT_MIN);
		end else begin
			scaled = AW'(quo);
		end
	end

	assign sum_next = sum_q + SW'(scaled_s2) - SW'(win_q[0]);
	assign sum_abs  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	assign qmag = (AW+1)'(prod_s4 >> tamahi_pkg::MEAN_SHIFT);
	assign mean = neg_s4 ? AW'(-qmag) : AW'(qmag);

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			prod_s1 <= axis * gain_s;
			val_s1  <= axis;
		end
		if (ctl.ld_s2) begin
			scaled_s2 <= scaled;
			val_s2    <= val_s1;
		end
		if (ctl.ld_s3) begin
			val_s3 <= val_s2;
		end
		if (ctl.ld_s4) begin
			prod_s4 <= BW'(sum_abs) * MW'(tamahi_pkg::MEAN_MULT);
			neg_s4  <= sum_q[SW-1];
			val_s4  <= val_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) begin
				win_q[i] <= '0;
			end
			sum_q <= '0;
			avg_q <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
		end else begin
			if (ctl.ld_s3 && ctl.push_s2) begin
				for (int i = 0; i < NW - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[NW-1] <= scaled_s2;
				sum_q       <= sum_next;
			end
			if (ctl.ld_s5) begin
				unique case (ctl.op_s4)
					tamahi_pkg::OP_SAMPLE: begin
						avg_q <= mean;
						if (ctl.track) begin
							if (lo_q > mean) lo_q <= mean;
							if (hi_q < mean) hi_q <= mean;
						end
					end
					tamahi_pkg::OP_CAL_START: begin
						lo_q <= '0;
						hi_q <= '0;
					end
					tamahi_pkg::OP_LOAD_MIN: lo_q <= val_s4;
					tamahi_pkg::OP_LOAD_MAX: hi_q <= val_s4;
					default: ;
				endcase
			end
		end
	end

	assign res.avg = avg_q;
	assign res.lo  = lo_q;
	assign res.hi  = hi_q;

endmodule
`default_nettype wire

>>> design/tamahi_merge.sv
// Output stage: joins the three lanes and applies the hard-iron offset.
`default_nettype none
module tamahi_merge (
	input  wire                                  clk,
	input  tamahi_pkg::pipe_ctl_t                ctl,
	input  tamahi_pkg::lane_res_t                res [3],
	output logic signed [tamahi_pkg::AXIS_W-1:0] mean_x,
	output logic signed [tamahi_pkg::AXIS_W-1:0] mean_y,
	output logic signed [tamahi_pkg::AXIS_W-1:0] mean_z,
	output logic signed [tamahi_pkg::CORR_W-1:0] corrected_x,
	output logic signed [tamahi_pkg::CORR_W-1:0] corrected_y,
	output logic signed [tamahi_pkg::CORR_W-1:0] corrected_z,
	output logic                                 calibrating
);

	localparam int AW = tamahi_pkg::AXIS_W;
	localparam int CW = tamahi_pkg::CORR_W;

	logic signed [CW-1:0] ext  [3];
	logic signed [CW-1:0] mid  [3];
	logic signed [CW-1:0] corr [3];
	logic signed [AW-1:0] mean_s6 [3];
	logic signed [CW-1:0] corr_s6 [3];
	logic                 cal_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext[i]  = CW'(res[i].hi) + CW'(res[i].lo);
			mid[i]  = (ext[i] + $signed(CW'(ext[i][CW-1]))) >>> 1;
			corr[i] = CW'(res[i].avg) - mid[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s6) begin
			for (int i = 0; i < 3; i++) begin
				mean_s6[i] <= res[i].avg;
				corr_s6[i] <= corr[i];
			end
			cal_s6 <= ctl.track;
		end
	end

	assign mean_x      = mean_s6[0];
	assign mean_y      = mean_s6[1];
	assign mean_z      = mean_s6[2];
	assign corrected_x = corr_s6[0];
	assign corrected_y = corr_s6[1];
	assign corrected_z = corr_s6[2];
	assign calibrating = cal_s6;

endmodule
`default_nettype wire

>>> design/three_axis_moving_average_hard_iron.sv
// Top level: request pipeline control, gain registers, three axis lanes and output stage.
`default_nettype none
// Takes one request per clock while the output side does not stall and returns one
// result per request. Each axis has its own lane: a 16x17 gain multiply, a ten-tap
// window with a running sum, a reciprocal multiply for the divide by the window length,
// and the extreme tracking, in a six-stage pipeline. The user must write the gain
// registers only while the block is idle; the block itself does not enforce it.
module three_axis_moving_average_hard_iron (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        wr_en,
	input  wire        [tamahi_pkg::REG_IDX_W-1:0]     wr_index,
	input  wire        [tamahi_pkg::GAIN_W-1:0]        wr_data,
	input  wire                                        in_valid,
	output logic                                       in_ready,
	input  wire        [2:0]                           opcode,
	input  wire signed [tamahi_pkg::AXIS_W-1:0]        axis_x,
	input  wire signed [tamahi_pkg::AXIS_W-1:0]        axis_y,
	input  wire signed [tamahi_pkg::AXIS_W-1:0]        axis_z,
	output logic                                       out_valid,
	input  wire                                        out_ready,
	output logic signed [tamahi_pkg::AXIS_W-1:0]       mean_x,
	output logic signed [tamahi_pkg::AXIS_W-1:0]       mean_y,
	output logic signed [tamahi_pkg::AXIS_W-1:0]       mean_z,
	output logic signed [tamahi_pkg::CORR_W-1:0]       corrected_x,
	output logic signed [tamahi_pkg::CORR_W-1:0]       corrected_y,
	output logic signed [tamahi_pkg::CORR_W-1:0]       corrected_z,
	output logic                                       calibrating
);

	logic [tamahi_pkg::GAIN_W-1:0] gain_q [3];
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                          go_s1, go_s2, go_s3, go_s4, go_s5, go_s6;
	logic                          ld_s1;
	tamahi_pkg::opcode_t           op_s1, op_s2, op_s3, op_s4;
	logic                          tracking_q;
	tamahi_pkg::pipe_ctl_t         ctl;
	tamahi_pkg::lane_res_t         res [3];

	// a stage moves on when the next one is empty or moving on itself
	assign go_s6 = v_s6 && out_ready;
	assign go_s5 = v_s5 && (!v_s6 || go_s6);
	assign go_s4 = v_s4 && (!v_s5 || go_s5);
	assign go_s3 = v_s3 && (!v_s4 || go_s4);
	assign go_s2 = v_s2 && (!v_s3 || go_s3);
	assign go_s1 = v_s1 && (!v_s2 || go_s2);
	assign in_ready  = !v_s1 || go_s1;
	assign ld_s1     = in_valid && in_ready;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			v_s6       <= 1'b0;
			tracking_q <= 1'b0;
			for (int i = 0; i < tamahi_pkg::NUM_REGS; i++) begin
				gain_q[i] <= tamahi_pkg::GAIN_W'(tamahi_pkg::GAIN_RESET);
			end
		end else begin
			v_s1 <= ld_s1 || (v_s1 && !go_s1);
			v_s2 <= go_s1 || (v_s2 && !go_s2);
			v_s3 <= go_s2 || (v_s3 && !go_s3);
			v_s4 <= go_s3 || (v_s4 && !go_s4);
			v_s5 <= go_s4 || (v_s5 && !go_s5);
			v_s6 <= go_s5 || (v_s6 && !go_s6);
			if (go_s4) begin
				if (op_s4 == tamahi_pkg::OP_CAL_START) begin
					tracking_q <= 1'b1;
				end else if (op_s4 == tamahi_pkg::OP_CAL_END) begin
					tracking_q <= 1'b0;
				end
			end
			if (wr_en) begin
				unique case (wr_index)
					tamahi_pkg::REG_INV_GAIN_X: gain_q[0] <= wr_data;
					tamahi_pkg::REG_INV_GAIN_Y: gain_q[1] <= wr_data;
					tamahi_pkg::REG_INV_GAIN_Z: gain_q[2] <= wr_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) op_s1 <= tamahi_pkg::opcode_t'(opcode);
		if (go_s1) op_s2 <= op_s1;
		if (go_s2) op_s3 <= op_s2;
		if (go_s3) op_s4 <= op_s3;
	end

	assign ctl.ld_s1   = ld_s1;
	assign ctl.ld_s2   = go_s1;
	assign ctl.ld_s3   = go_s2;
	assign ctl.ld_s4   = go_s3;
	assign ctl.ld_s5   = go_s4;
	assign ctl.ld_s6   = go_s5;
	assign ctl.push_s2 = (op_s2 == tamahi_pkg::OP_SAMPLE);
	assign ctl.op_s4   = op_s4;
	assign ctl.track   = tracking_q;

	tamahi_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.gain   (gain_q[0]),
		.axis   (axis_x),
		.res    (res[0])
	);

	tamahi_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.gain   (gain_q[1]),
		.axis   (axis_y),
		.res    (res[1])
	);

	tamahi_lane u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.gain   (gain_q[2]),
		.axis   (axis_z),
		.res    (res[2])
	);

	tamahi_merge u_merge (
		.clk         (clk),
		.ctl         (ctl),
		.res         (res),
		.mean_x      (mean_x),
		.mean_y      (mean_y),
		.mean_z      (mean_z),
		.corrected_x (corrected_x),
		.corrected_y (corrected_y),
		.corrected_z (corrected_z),
		.calibrating (calibrating)
	);

	a_cal_start_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s4 && op_s4 == tamahi_pkg::OP_CAL_START) |=> tracking_q)
		else $error("tracking not set after calibration start");

	a_track_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!go_s4 |=> $stable(tracking_q))
		else $error("tracking changed without a request in the update stage");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !out_ready) |-> !in_ready)
		else $error("request taken into a full stalled pipeline");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("empty first stage refuses a request");

endmodule
`default_nettype wire
